[sv/pm_frame_parse_average_top_assert.svh]
// Assertion macros for the particulate frame decoder top level.
`ifndef PM_FRAME_PARSE_AVERAGE_TOP_ASSERT_SVH
`define PM_FRAME_PARSE_AVERAGE_TOP_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define PFPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfpa: implication violated");

// cond must never hold.
`define PFPA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pfpa: forbidden condition seen");

`endif

[sv/pfpa_pkg.sv]
// Shared constants, codes and types of the particulate frame decoder.
`timescale 1ns / 1ps
package pfpa_pkg;

  localparam int FRAME_LEN  = 10;
  localparam int POS_BITS   = $clog2(FRAME_LEN + 1);
  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = 32;
  localparam int WORD_BITS  = 16;
  localparam int STEP_BITS  = $clog2(SUM_BITS);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] CMD_BYTE  = 8'hC0;
  localparam logic [7:0] TAIL_BYTE = 8'hAB;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ERR    = 2'd1,
    ST_NODATA = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_ERR = 2'd1,
    OP_EOB = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e                  op;
    logic                 head_seen;
    logic [WORD_BITS-1:0] pm25;
    logic [WORD_BITS-1:0] pm10;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[sv/pfpa_if.sv]
// Handshake interfaces for the input byte channel and the result channel.
`timescale 1ns / 1ps
interface pfpa_in_if ();
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_value;

  modport source (output valid, func, byte_value, input ready);
  modport sink (input valid, func, byte_value, output ready);
endinterface

interface pfpa_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pm25_avg;
  logic [15:0] pm10_avg;

  modport source (output valid, status, pm25_avg, pm10_avg, input ready);
  modport sink (input valid, status, pm25_avg, pm10_avg, output ready);
endinterface

[sv/pfpa_front.sv]
// Front end: frame store, head detection, frame checks and command issue.
`timescale 1ns / 1ps
module pfpa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfpa_in_if.sink           in_i,
  input  pfpa_pkg::q_stat_t q_stat_i,
  output logic              q_push_o,
  output pfpa_pkg::cmd_t    q_cmd_o
);

  logic [7:0]                    bytes_q [pfpa_pkg::FRAME_LEN];
  logic [pfpa_pkg::POS_BITS-1:0] pos_q, pos_d;
  logic                          head_q, head_d;
  logic                          wr_en;
  logic [pfpa_pkg::POS_BITS-1:0] wr_idx;
  logic                          accept;
  logic [7:0]                    crc;
  logic                          frame_ok;
  logic                          is_head;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign is_head    = (in_i.byte_value == pfpa_pkg::HEAD_BYTE);

  assign crc = bytes_q[2] + bytes_q[3] + bytes_q[4] + bytes_q[5] + bytes_q[6] + bytes_q[7];
  assign frame_ok = (pos_q == pfpa_pkg::POS_BITS'(pfpa_pkg::FRAME_LEN)) &&
                    (bytes_q[1] == pfpa_pkg::CMD_BYTE) &&
                    (bytes_q[9] == pfpa_pkg::TAIL_BYTE);

  always_comb begin
    q_push_o          = 1'b0;
    q_cmd_o.op        = pfpa_pkg::OP_ADD;
    q_cmd_o.head_seen = head_q;
    q_cmd_o.pm25      = {bytes_q[3], bytes_q[2]};
    q_cmd_o.pm10      = {bytes_q[5], bytes_q[4]};
    head_d            = head_q;
    pos_d             = pos_q;
    wr_en             = 1'b0;
    wr_idx            = '0;
    if (accept) begin
      if (in_i.func) begin
        q_push_o   = 1'b1;
        q_cmd_o.op = pfpa_pkg::OP_EOB;
      end else if (is_head && head_q && frame_ok && (crc != bytes_q[8])) begin
        // Bad checksum: report, keep the store and drop this head byte.
        q_push_o   = 1'b1;
        q_cmd_o.op = pfpa_pkg::OP_ERR;
      end else begin
        if (is_head && head_q && frame_ok) begin
          q_push_o = 1'b1;
        end
        wr_en = 1'b1;
        if (is_head || (pos_q >= pfpa_pkg::POS_BITS'(pfpa_pkg::FRAME_LEN))) begin
          head_d = head_q | is_head;
          wr_idx = '0;
          pos_d  = pfpa_pkg::POS_BITS'(1);
        end else begin
          wr_idx = pos_q;
          pos_d  = pos_q + pfpa_pkg::POS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      head_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bytes_q[wr_idx] <= in_i.byte_value;
    end
  end

endmodule

[sv/pfpa_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module pfpa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfpa_pkg::cmd_t    push_cmd_i,
  input  logic              pop_i,
  output pfpa_pkg::cmd_t    head_cmd_o,
  output pfpa_pkg::q_stat_t stat_o
);

  pfpa_pkg::cmd_t                  entries_q [pfpa_pkg::Q_DEPTH];
  logic [pfpa_pkg::Q_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [pfpa_pkg::Q_PTR_BITS:0]   count_q;

  assign head_cmd_o   = entries_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (pfpa_pkg::Q_PTR_BITS + 1)'(pfpa_pkg::Q_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + pfpa_pkg::Q_PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + pfpa_pkg::Q_PTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (pfpa_pkg::Q_PTR_BITS + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (pfpa_pkg::Q_PTR_BITS + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[sv/pfpa_back.sv]
// Back end: burst sums, frame count, serial divider and result register.
`timescale 1ns / 1ps
module pfpa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfpa_pkg::cmd_t    q_cmd_i,
  input  pfpa_pkg::q_stat_t q_stat_i,
  output logic              q_pop_o,
  pfpa_out_if.source        out_o
);

  localparam int CB = pfpa_pkg::COUNT_BITS;
  localparam int SB = pfpa_pkg::SUM_BITS;
  localparam int WB = pfpa_pkg::WORD_BITS;

  pfpa_pkg::back_state_e          state_q, state_d;
  logic [CB-1:0]                  count_q, count_d;
  logic [SB-1:0]                  sum25_q, sum25_d, sum10_q, sum10_d;
  logic [SB-1:0]                  div25_q, div25_d, div10_q, div10_d;
  logic [CB:0]                    rem25_q, rem25_d, rem10_q, rem10_d;
  logic [pfpa_pkg::STEP_BITS-1:0] step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic [1:0]                     out_status_q, out_status_d;
  logic [WB-1:0]                  out25_q, out25_d, out10_q, out10_d;

  logic          slot_free;
  logic          load_out;
  logic [SB:0]   add25, add10;
  logic [CB:0]   sh25, sh10, divisor;
  logic          ge25, ge10;

  assign slot_free = !out_valid_q || out_o.ready;

  assign add25 = {1'b0, sum25_q} + (SB + 1)'(q_cmd_i.pm25);
  assign add10 = {1'b0, sum10_q} + (SB + 1)'(q_cmd_i.pm10);

  // One restoring division step per cycle for both sums.
  assign divisor = {1'b0, count_q};
  assign sh25    = {rem25_q[CB-1:0], div25_q[SB-1]};
  assign sh10    = {rem10_q[CB-1:0], div10_q[SB-1]};
  assign ge25    = (sh25 >= divisor);
  assign ge10    = (sh10 >= divisor);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sum25_d      = sum25_q;
    sum10_d      = sum10_q;
    div25_d      = div25_q;
    div10_d      = div10_q;
    rem25_d      = rem25_q;
    rem10_d      = rem10_q;
    step_d       = step_q;
    q_pop_o      = 1'b0;
    load_out     = 1'b0;
    out_status_d = out_status_q;
    out25_d      = out25_q;
    out10_d      = out10_q;
    case (state_q)
      pfpa_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          case (q_cmd_i.op)
            pfpa_pkg::OP_ADD: begin
              q_pop_o = 1'b1;
              if (count_q != pfpa_pkg::COUNT_MAX) begin
                count_d = count_q + CB'(1);
                sum25_d = add25[SB] ? '1 : add25[SB-1:0];
                sum10_d = add10[SB] ? '1 : add10[SB-1:0];
              end
            end
            pfpa_pkg::OP_ERR: begin
              if (slot_free) begin
                q_pop_o      = 1'b1;
                load_out     = 1'b1;
                out_status_d = pfpa_pkg::ST_ERR;
                out25_d      = '0;
                out10_d      = '0;
                count_d      = '0;
                sum25_d      = '0;
                sum10_d      = '0;
              end
            end
            pfpa_pkg::OP_EOB: begin
              if (q_cmd_i.head_seen && (count_q != '0)) begin
                div25_d = sum25_q;
                div10_d = sum10_q;
                rem25_d = '0;
                rem10_d = '0;
                step_d  = '0;
                state_d = pfpa_pkg::BK_DIV;
              end else if (slot_free) begin
                q_pop_o      = 1'b1;
                load_out     = 1'b1;
                out_status_d = pfpa_pkg::ST_NODATA;
                out25_d      = '0;
                out10_d      = '0;
                count_d      = '0;
                sum25_d      = '0;
                sum10_d      = '0;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      pfpa_pkg::BK_DIV: begin
        rem25_d = ge25 ? (sh25 - divisor) : sh25;
        rem10_d = ge10 ? (sh10 - divisor) : sh10;
        div25_d = {div25_q[SB-2:0], ge25};
        div10_d = {div10_q[SB-2:0], ge10};
        step_d  = step_q + pfpa_pkg::STEP_BITS'(1);
        if (step_q == pfpa_pkg::STEP_BITS'(SB - 1)) begin
          state_d = pfpa_pkg::BK_DONE;
        end
      end
      pfpa_pkg::BK_DONE: begin
        // Hold the quotients until the result register frees up.
        if (slot_free) begin
          q_pop_o      = 1'b1;
          load_out     = 1'b1;
          out_status_d = pfpa_pkg::ST_OK;
          out25_d      = div25_q[WB-1:0];
          out10_d      = div10_q[WB-1:0];
          count_d      = '0;
          sum25_d      = '0;
          sum10_d      = '0;
          state_d      = pfpa_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = pfpa_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfpa_pkg::BK_IDLE;
      count_q     <= '0;
      sum25_q     <= '0;
      sum10_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum25_q     <= sum25_d;
      sum10_q     <= sum10_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div25_q      <= div25_d;
    div10_q      <= div10_d;
    rem25_q      <= rem25_d;
    rem10_q      <= rem10_d;
    out_status_q <= out_status_d;
    out25_q      <= out25_d;
    out10_q      <= out10_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.pm25_avg = out25_q;
  assign out_o.pm10_avg = out10_q;

endmodule

[sv/pm_frame_parse_average_top.sv]
// Particulate sensor frame decoder with burst averaging (top level).
//
// in_i carries one transaction per serial byte (func = 0, byte_value) or per
// end-of-burst marker (func = 1). out_o carries status, pm25_avg, pm10_avg.
// Bytes are taken one per cycle while the command queue is not full; a frame
// is judged when the next 0xAA head byte arrives. A bad checksum gives a
// status 1 result; end of burst gives the averages (status 0) or no data
// (status 2). An error or no-data result passes through the command queue and
// then the result register; an end-of-burst result with averages also waits
// for the back end's bit-serial divider, which works one quotient bit of
// both sums a cycle.
// The front end keeps taking bytes while the back end divides, until the
// four-entry command queue fills; then ready drops until the back end pops one.
// Reset clears position, head flag, count, sums, queue and result valid;
// no clearing pass is needed. When the receiver stalls, the result register
// holds and the back end waits at its next result, so commands queue up.
`timescale 1ns / 1ps
`include "pm_frame_parse_average_top_assert.svh"
module pm_frame_parse_average_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfpa_in_if.sink     in_i,
  pfpa_out_if.source  out_o
);

  logic              q_push;
  logic              q_pop;
  pfpa_pkg::cmd_t    push_cmd;
  pfpa_pkg::cmd_t    head_cmd;
  pfpa_pkg::q_stat_t q_stat;

  pfpa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  pfpa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_cmd_o (head_cmd),
    .stat_o     (q_stat)
  );

  pfpa_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_cmd_i  (head_cmd),
    .q_stat_i (q_stat),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

  `PFPA_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, q_push && q_stat.full)
  `PFPA_ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, q_pop && q_stat.empty)
  `PFPA_ASSERT_IMPLY(a_zero_avg_unless_ok, clk_i, rst_ni,
      out_o.valid && (out_o.status != pfpa_pkg::ST_OK),
      (out_o.pm25_avg == '0) && (out_o.pm10_avg == '0))

endmodule
